### rtl/utf8_to_utf16_decoder_macros.svh
// assertion macros for the utf-8 to utf-16 decoder
`ifndef UTF8_TO_UTF16_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, reset-qualified
`define U8U16_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8u16 check failed");
// next-cycle implication, reset-qualified
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8u16 check failed");
`else
`define U8U16_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/u8u16_pkg.sv
// types and constants shared by the utf-8 to utf-16 decoder
`timescale 1ns / 1ps
package u8u16_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] BUF_UNITS_RST  = 16'd256;
  localparam logic [15:0] CU_REPLACEMENT = 16'hFFFD;
  localparam logic [15:0] CU_HI_SURR     = 16'hD800;
  localparam logic [15:0] CU_LO_SURR     = 16'hDC00;
  localparam logic [20:0] CP_SURR_LO     = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI     = 21'h00DFFF;
  localparam logic [20:0] CP_MAX         = 21'h10FFFF;
  localparam logic [20:0] CP_PLANE1      = 21'h010000;

  // per-string decode state
  typedef struct packed {
    logic [20:0] accum;
    logic [1:0]  pending;
    logic [1:0]  seq_len;
    logic [15:0] unit_cnt;
  } dec_state_t;

  // one result item
  typedef struct packed {
    logic [15:0] units;
    logic        str_end;
    logic        last;
    logic [15:0] code;
  } res_item_t;

  // results caused by one input byte
  typedef struct packed {
    logic [1:0] num;
    res_item_t  item1;
    res_item_t  item0;
  } dec_res_t;

endpackage

### rtl/utf8_to_utf16_decoder.sv
// utf-8 to utf-16 decoder top level: state registers and result queue
// an accepted byte's result items are registered in the result queue and leave from its head
// throughput: one byte per cycle while the four-entry result queue has room for two items,
//   since one byte can push up to two items (a surrogate pair)
// reset: synchronous active-low rst_n clears decode state and the queue,
//   buffer_units returns to 256
`timescale 1ns / 1ps
`include "utf8_to_utf16_decoder_macros.svh"
module utf8_to_utf16_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // buffer_units
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // code_unit [15:0], units_written [31:16]
  output logic        out_tlast,     // last_in_run
  output logic        out_tuser      // string_end
);
  import u8u16_pkg::*;

  logic [15:0]     buf_units_r;
  logic [15:0]     unit_limit;
  dec_state_t      state_r;
  dec_state_t      state_nxt;
  dec_res_t        dec_res;
  res_item_t       queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   q_cnt_r, q_cnt_nxt;
  logic [QPTR_W-1:0] wr_ptr_p1;
  logic              in_fire;
  logic              out_fire;
  logic [1:0]        push_num;
  res_item_t         head;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_units_r <= BUF_UNITS_RST;
    end else if (cfg_wr_en) begin
      buf_units_r <= cfg_wr_data;
    end
  end

  // one slot is kept for the terminator
  assign unit_limit = (buf_units_r == 16'd0) ? 16'd0 : buf_units_r - 16'd1;

  u8u16_decode u_decode (
    .in_byte    (in_tdata),
    .unit_limit (unit_limit),
    .cur        (state_r),
    .nxt        (state_nxt),
    .res        (dec_res)
  );

  // handshake: room for a full pair is needed to take a byte
  assign in_tready = (q_cnt_r <= (QPTR_W+1)'(QUEUE_DEPTH - 2));
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (q_cnt_r != '0);
  assign out_fire  = out_tvalid && out_tready;
  assign push_num  = in_fire ? dec_res.num : 2'd0;
  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);

  // decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push_num);
    rd_ptr_nxt = out_fire ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    q_cnt_nxt  = q_cnt_r + (QPTR_W+1)'(push_num) - (QPTR_W+1)'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // queue storage, up to two items written per byte
  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      queue_r[wr_ptr_r] <= dec_res.item0;
    end
    if (push_num == 2'd2) begin
      queue_r[wr_ptr_p1] <= dec_res.item1;
    end
  end

  // result item at the head
  assign head      = queue_r[rd_ptr_r];
  assign out_tdata = {head.units, head.code};
  assign out_tlast = head.last;
  assign out_tuser = head.str_end;

  // checks
  `U8U16_ASSERT_IMPL(a_q_bound, clk, rst_n, 1'b1, q_cnt_r <= (QPTR_W+1)'(QUEUE_DEPTH))
  `U8U16_ASSERT_IMPL(a_rdy_room, clk, rst_n, in_tready, q_cnt_r <= (QPTR_W+1)'(QUEUE_DEPTH - 2))
  `U8U16_ASSERT_NEXT(a_term_clr, clk, rst_n, in_fire && in_tdata == 8'd0, state_r == '0)
  `U8U16_ASSERT_IMPL(a_term_last, clk, rst_n, out_tvalid && out_tuser, out_tlast)

endmodule

### rtl/u8u16_decode.sv
// byte decode step: next state and the result items for one utf-8 byte
`timescale 1ns / 1ps
module u8u16_decode (
  input  logic [7:0]            in_byte,
  input  logic [15:0]           unit_limit,
  input  u8u16_pkg::dec_state_t cur,
  output u8u16_pkg::dec_state_t nxt,
  output u8u16_pkg::dec_res_t   res
);
  import u8u16_pkg::*;

  logic [20:0] cp;
  logic [20:0] diff;
  logic [19:0] d20;
  logic [16:0] cnt_p1;

  assign cp     = {cur.accum[14:0], in_byte[5:0]};
  assign diff   = cp - CP_PLANE1;
  assign d20    = diff[19:0];
  assign cnt_p1 = {1'b0, cur.unit_cnt} + 17'd1;

  always_comb begin
    nxt = cur;
    res = '0;
    if (in_byte == 8'd0) begin
      // terminator with count, clear string state
      res.num           = 2'd1;
      res.item0.last    = 1'b1;
      res.item0.str_end = 1'b1;
      res.item0.units   = cur.unit_cnt;
      nxt               = '0;
    end else if (cur.pending != 2'd0) begin
      // continuation byte
      nxt.accum   = cp;
      nxt.pending = cur.pending - 2'd1;
      if (cur.pending == 2'd1) begin
        if (cur.seq_len == 2'd3) begin
          if (cnt_p1 < {1'b0, unit_limit}) begin
            if (cp <= CP_MAX) begin
              res.num        = 2'd2;
              res.item0.code = CU_HI_SURR | {6'd0, d20[19:10]};
              res.item1.code = CU_LO_SURR | {6'd0, d20[9:0]};
              res.item1.last = 1'b1;
            end else begin
              res.num        = 2'd1;
              res.item0.code = CU_REPLACEMENT;
              res.item0.last = 1'b1;
            end
          end
        end else if (cur.unit_cnt < unit_limit) begin
          res.num        = 2'd1;
          res.item0.last = 1'b1;
          if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) begin
            res.item0.code = CU_REPLACEMENT;
          end else begin
            res.item0.code = cp[15:0];
          end
        end
      end
    end else if (cur.unit_cnt < unit_limit) begin
      // lead byte
      if (in_byte[7] == 1'b0) begin
        res.num        = 2'd1;
        res.item0.code = {8'd0, in_byte};
        res.item0.last = 1'b1;
      end else if (in_byte[7:5] == 3'b110) begin
        nxt.accum   = {16'd0, in_byte[4:0]};
        nxt.seq_len = 2'd1;
        nxt.pending = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        nxt.accum   = {17'd0, in_byte[3:0]};
        nxt.seq_len = 2'd2;
        nxt.pending = 2'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
        nxt.accum   = {18'd0, in_byte[2:0]};
        nxt.seq_len = 2'd3;
        nxt.pending = 2'd3;
      end else begin
        res.num        = 2'd1;
        res.item0.code = CU_REPLACEMENT;
        res.item0.last = 1'b1;
      end
    end
    // units written by this byte
    if (in_byte != 8'd0) begin
      nxt.unit_cnt = cur.unit_cnt + {14'd0, res.num};
    end
  end

endmodule
